### src/irla_pkg.sv
// ----------------------------------------------------------------------------
// irla_pkg
// Shared types and codes of the interrupt line run allocator: request and
// status codes, and the command and status bundles that join the controller
// to the datapath.
// ----------------------------------------------------------------------------
package irla_pkg;

   localparam int unsigned GLOBAL_W  = 16;
   localparam int unsigned COUNT_W   = 9;
   localparam int unsigned LEN_W     = 9;
   localparam int unsigned LINE_W    = 8;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 16;
   // global numbers plus a run length never pass 17 bits
   localparam int unsigned WIDE_W    = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_DOMAIN_BASE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOMAIN_COUNT = 1'd1;

   localparam logic [COUNT_W-1:0] DOMAIN_COUNT_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_MARK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STS_OK      = 3'd0,
      STS_INVALID = 3'd1,
      STS_NO_RUN  = 3'd2,
      STS_RANGE   = 3'd3,
      STS_NOTHING = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      IDX_HOLD   = 3'd0,
      IDX_ZERO   = 3'd1,
      IDX_INC    = 3'd2,
      IDX_GLOBAL = 3'd3,
      IDX_LINE   = 3'd4
   } idx_op_type;

   typedef enum logic [1:0] {
      IRQ_ZERO  = 2'd0,
      IRQ_START = 2'd1,
      IRQ_LINE  = 2'd2
   } irq_sel_type;

   typedef struct packed {
      logic        op_load;
      idx_op_type  idx_op;
      logic        scan_init;
      logic        scan;
      logic        rem_load;
      logic        rem_dec;
      logic        wr_en;
      logic        wr_val;
      logic        rsp_load;
      status_type  res_code;
      irq_sel_type irq_sel;
   } ctl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   alloc_bad;
      logic   free_bad;
      logic   free_zero;
      logic   mark_bad;
      logic   clr_bad;
      logic   found;
      logic   exhausted;
      logic   idx_last;
      logic   rem_last;
      logic   line_set;
      logic   rsp_busy;
   } ctl_stat_type;

endpackage

### src/irla_req_if.sv
// ----------------------------------------------------------------------------
// irla_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface irla_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [15:0] global_irq;
   logic [7:0] line_index;
   logic [8:0] run_length;

   modport source (output valid, output op, output global_irq, output line_index,
                   output run_length, input ready);
   modport sink   (input valid, input op, input global_irq, input line_index,
                   input run_length, output ready);
endinterface

### src/irla_rsp_if.sv
// ----------------------------------------------------------------------------
// irla_rsp_if
// Response channel: valid/ready handshake with status and global number.
// ----------------------------------------------------------------------------
interface irla_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] result_irq;

   modport source (output valid, output status, output result_irq, input ready);
   modport sink   (input valid, input status, input result_irq, output ready);
endinterface

### src/irla_ctrl.sv
// ----------------------------------------------------------------------------
// irla_ctrl
// Request sequencer: clears the bitmap after reset, decodes each request,
// steps the scan, fill and free sweeps, and hands the result to the output
// register.
// ----------------------------------------------------------------------------
module irla_ctrl import irla_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output ctl_cmd_type  cmd,
   input  ctl_stat_type st
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_FILL,
      S_FREE,
      S_MARK,
      S_CLR_RD,
      S_CLR_EV,
      S_DONE
   } state_type;

   state_type   state_ff, state_in;
   status_type  code_ff, code_in;
   irq_sel_type sel_ff, sel_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      code_in   = code_ff;
      sel_in    = sel_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_val = 1'b0;
            cmd.idx_op = IDX_INC;
            if (st.idx_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op_load = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            sel_in = IRQ_ZERO;
            case (st.op)
               OP_ALLOC: begin
                  if (st.alloc_bad) begin
                     code_in  = STS_INVALID;
                     state_in = S_DONE;
                  end else begin
                     cmd.idx_op    = IDX_ZERO;
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               OP_FREE: begin
                  if (st.free_bad) begin
                     code_in  = STS_RANGE;
                     state_in = S_DONE;
                  end else if (st.free_zero) begin
                     code_in  = STS_NOTHING;
                     state_in = S_DONE;
                  end else begin
                     cmd.idx_op   = IDX_GLOBAL;
                     cmd.rem_load = 1'b1;
                     state_in     = S_FREE;
                  end
               end
               OP_MARK: begin
                  if (st.mark_bad) begin
                     code_in  = STS_RANGE;
                     state_in = S_DONE;
                  end else begin
                     cmd.idx_op = IDX_LINE;
                     state_in   = S_MARK;
                  end
               end
               OP_CLEAR: begin
                  if (st.clr_bad) begin
                     code_in  = STS_RANGE;
                     state_in = S_DONE;
                  end else begin
                     cmd.idx_op = IDX_GLOBAL;
                     state_in   = S_CLR_RD;
                  end
               end
               default: begin
                  code_in  = STS_INVALID;
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan     = 1'b1;
            cmd.rem_load = 1'b1;
            if (st.found) begin
               code_in  = STS_OK;
               sel_in   = IRQ_START;
               state_in = S_FILL;
            end else if (st.exhausted) begin
               code_in  = STS_NO_RUN;
               sel_in   = IRQ_ZERO;
               state_in = S_DONE;
            end
         end
         S_FILL: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_val  = 1'b1;
            cmd.idx_op  = IDX_INC;
            cmd.rem_dec = 1'b1;
            if (st.rem_last) begin
               state_in = S_DONE;
            end
         end
         S_FREE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_val  = 1'b0;
            cmd.idx_op  = IDX_INC;
            cmd.rem_dec = 1'b1;
            code_in     = STS_OK;
            sel_in      = IRQ_ZERO;
            if (st.rem_last) begin
               state_in = S_DONE;
            end
         end
         S_MARK: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_val = 1'b1;
            code_in    = STS_OK;
            sel_in     = IRQ_LINE;
            state_in   = S_DONE;
         end
         S_CLR_RD: begin
            // wait for the registered bitmap read
            state_in = S_CLR_EV;
         end
         S_CLR_EV: begin
            sel_in = IRQ_ZERO;
            if (st.line_set) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_val = 1'b0;
               code_in    = STS_OK;
            end else begin
               code_in = STS_NOTHING;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!st.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.res_code = code_ff;
      cmd.irq_sel  = sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= STS_OK;
         sel_ff   <= IRQ_ZERO;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         sel_ff   <= sel_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !st.rsp_busy)
      else $error("response loaded over a pending response");

   a_no_req_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request taken before the bitmap sweep");

   a_scan_one_outcome: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !(st.found && st.exhausted))
      else $error("scan found a run and ran out together");

endmodule

### src/irla_dpath.sv
// ----------------------------------------------------------------------------
// irla_dpath
// Datapath: domain registers, request capture, range checks, the in-use
// bitmap memory with its line counter, the run scan and the response
// register.
// ----------------------------------------------------------------------------
module irla_dpath import irla_pkg::*; #(
   parameter int unsigned LINES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [1:0]            req_op,
   input  logic [GLOBAL_W-1:0]   req_global_irq,
   input  logic [LINE_W-1:0]     req_line_index,
   input  logic [LEN_W-1:0]      req_run_length,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [GLOBAL_W-1:0]   rsp_result_irq,
   input  ctl_cmd_type           cmd,
   output ctl_stat_type          st
);

   localparam int unsigned IW = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int unsigned CW = $clog2(LINES + 1);

   logic [GLOBAL_W-1:0] base_ff;
   logic [COUNT_W-1:0]  count_ff;
   op_type              op_ff;
   logic [GLOBAL_W-1:0] girq_ff;
   logic [LINE_W-1:0]   lidx_ff;
   logic [LEN_W-1:0]    len_ff;

   logic                line_mem [LINES];
   logic                rdata_ff;

   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [CW-1:0]       run_ff, run_in;
   logic [CW-1:0]       start_ff, start_in;
   logic [CW-1:0]       chk_idx_ff;
   logic                chk_vld_ff, chk_vld_in;

   logic                rsp_vld_ff;
   status_type          status_ff;
   logic [GLOBAL_W-1:0] irq_ff;

   logic [CW-1:0]       cnt;
   logic [CW-1:0]       len_cw;
   logic [WIDE_W-1:0]   base_w, cnt_w, end_w, girq_w, len_w, gofs_w;
   logic [CW-1:0]       run_next;
   logic [CW-1:0]       found_start;
   logic                found;
   logic                more;
   logic [IW-1:0]       addr;

   // a count above the bitmap size acts as the bitmap size
   always_comb begin
      if (32'(count_ff) > 32'(LINES)) begin
         cnt = CW'(LINES);
      end else begin
         cnt = CW'(count_ff);
      end
   end

   assign len_cw = CW'(len_ff);
   assign base_w = WIDE_W'(base_ff);
   assign cnt_w  = WIDE_W'(cnt);
   assign end_w  = base_w + cnt_w;
   assign girq_w = WIDE_W'(girq_ff);
   assign len_w  = WIDE_W'(len_ff);
   assign gofs_w = girq_w - base_w;

   assign addr = idx_ff[IW-1:0];
   assign more = (idx_ff < cnt);

   // run scan: the read issued last cycle comes back tagged with chk_idx_ff
   assign run_next    = rdata_ff ? '0 : run_ff + CW'(1);
   assign found       = cmd.scan && chk_vld_ff && !rdata_ff && (run_next == len_cw);
   assign found_start = chk_idx_ff + CW'(1) - len_cw;

   always_comb begin
      idx_in = idx_ff;
      case (cmd.idx_op)
         IDX_HOLD:   idx_in = idx_ff;
         IDX_ZERO:   idx_in = '0;
         IDX_INC:    idx_in = idx_ff + CW'(1);
         IDX_GLOBAL: idx_in = CW'(gofs_w);
         IDX_LINE:   idx_in = CW'(lidx_ff);
         default:    idx_in = idx_ff;
      endcase
      if (cmd.scan) begin
         if (found) begin
            idx_in = found_start;
         end else if (more) begin
            idx_in = idx_ff + CW'(1);
         end
      end
   end

   always_comb begin
      chk_vld_in = chk_vld_ff;
      run_in     = run_ff;
      start_in   = start_ff;
      if (cmd.scan_init) begin
         chk_vld_in = 1'b0;
         run_in     = '0;
      end else if (cmd.scan) begin
         chk_vld_in = more && !found;
         if (chk_vld_ff) begin
            run_in = run_next;
         end
         if (found) begin
            start_in = found_start;
         end
      end
   end

   always_comb begin
      rem_in = rem_ff;
      if (cmd.rem_load) begin
         rem_in = len_cw;
      end else if (cmd.rem_dec) begin
         rem_in = rem_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         count_ff   <= DOMAIN_COUNT_RESET;
         idx_ff     <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DOMAIN_BASE:  base_ff  <= csr_wdata;
               CSR_DOMAIN_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
               default:          base_ff  <= base_ff;
            endcase
         end
         idx_ff     <= idx_in;
         chk_vld_ff <= chk_vld_in;
         if (cmd.rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op_load) begin
         op_ff   <= op_type'(req_op);
         girq_ff <= req_global_irq;
         lidx_ff <= req_line_index;
         len_ff  <= req_run_length;
      end
      rem_ff     <= rem_in;
      run_ff     <= run_in;
      start_ff   <= start_in;
      chk_idx_ff <= idx_ff;
      if (cmd.rsp_load) begin
         status_ff <= cmd.res_code;
         case (cmd.irq_sel)
            IRQ_START: irq_ff <= base_ff + GLOBAL_W'(start_ff);
            IRQ_LINE:  irq_ff <= base_ff + GLOBAL_W'(lidx_ff);
            default:   irq_ff <= '0;
         endcase
      end
   end

   // in-use bitmap: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         line_mem[addr] <= cmd.wr_val;
      end
      rdata_ff <= line_mem[addr];
   end

   always_comb begin
      st.op        = op_ff;
      st.alloc_bad = (len_ff == '0) || (len_w > cnt_w);
      st.free_bad  = (girq_w < base_w) || (girq_w + len_w > end_w) || (girq_w >= end_w);
      st.free_zero = (len_ff == '0);
      st.mark_bad  = (WIDE_W'(lidx_ff) >= cnt_w);
      st.clr_bad   = (girq_w < base_w) || (girq_w >= end_w);
      st.found     = found;
      st.exhausted = cmd.scan && !chk_vld_ff && !more;
      st.idx_last  = (idx_ff == CW'(LINES - 1));
      st.rem_last  = (rem_ff == CW'(1));
      st.line_set  = rdata_ff;
      st.rsp_busy  = rsp_vld_ff && !rsp_ready;
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_status     = status_ff;
   assign rsp_result_irq = irq_ff;

   a_write_in_map: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (idx_ff < CW'(LINES)))
      else $error("bitmap write beyond the last line");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(cmd.rsp_load))
      else $error("response raised without a load");

   a_found_start_ok: assert property (@(posedge clock) disable iff (reset)
      found |-> ((chk_idx_ff + CW'(1)) >= len_cw))
      else $error("found run starts before line zero");

endmodule

### src/irq_line_run_allocator.sv
// ----------------------------------------------------------------------------
// irq_line_run_allocator
// First-fit allocator of contiguous interrupt line runs over an in-use
// bitmap, with free-run, mark-one and clear-one requests.
//
//   channel   direction  handshake       payload
//   req_ch    in         valid / ready   op, global_irq, line_index, run_length
//   rsp_ch    out        valid / ready   status, result_irq
//   csr_*     in         csr_we          csr_index, csr_wdata
//
// One request at a time; the bitmap is a one-port memory, one line a cycle.
// Allocate scans the domain for a free run and, when one fits, fills it; the
// free-run request clears each line of the run; mark one sets one line; clear
// one reads one line and clears it when it is set.
// After reset a clearing pass over every bitmap line runs before the first request.
// A stalled response holds the next result; the next request is taken
// while a finished response waits.
// ----------------------------------------------------------------------------
module irq_line_run_allocator import irla_pkg::*; #(
   parameter int unsigned LINES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   irla_req_if.sink              req_ch,
   irla_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_cmd_type  cmd;
   ctl_stat_type st;

   irla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .st        (st)
   );

   irla_dpath #(
      .LINES (LINES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_op         (req_ch.op),
      .req_global_irq (req_ch.global_irq),
      .req_line_index (req_ch.line_index),
      .req_run_length (req_ch.run_length),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_status     (rsp_ch.status),
      .rsp_result_irq (rsp_ch.result_irq),
      .cmd            (cmd),
      .st             (st)
   );

endmodule
